@@ rtl/leaky_softsign_reservoir_bank_top_assert.svh @@
// assertion macros for the reservoir bank checker
`ifndef LEAKY_SOFTSIGN_RESERVOIR_BANK_TOP_ASSERT_SVH
`define LEAKY_SOFTSIGN_RESERVOIR_BANK_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LSRB_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsrb check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define LSRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsrb check failed");

`endif

@@ rtl/lsrb_pkg.sv @@
// ----------------------------------------------------------------------------
// lsrb_pkg
// types and constants shared by the reservoir bank modules
// ----------------------------------------------------------------------------
package lsrb_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned MaxBank     = 64;
  localparam int unsigned ChW   = $clog2(MaxChannels);
  localparam int unsigned PtrW  = $clog2(MaxBank);
  localparam int unsigned AddrW = ChW + PtrW;
  localparam int unsigned Depth = MaxChannels * MaxBank;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegChannelCount = 3'd0,
    RegBankSize     = 3'd1,
    RegLeak         = 3'd2,
    RegInputGain    = 3'd3,
    RegFeedbackGain = 3'd4
  } reg_idx_e;

  localparam logic [0:0] ReqProcess = 1'b0;
  localparam logic [0:0] ReqRead    = 1'b1;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [2:0]  channel;
    logic signed [15:0] sample;
    logic [5:0]  age_index;
  } req_t;

  typedef struct packed {
    logic signed [15:0] cell_value;
    logic [0:0]         status;
  } rsp_t;

  typedef enum logic [3:0] {
    StClear, StIdle, StRead1, StRead2, StDrive, StSat, StDiv, StMix, StMix2, StWrite,
    StOut
  } state_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [15:0] mag;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/lsrb_if.sv @@
// ----------------------------------------------------------------------------
// lsrb_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface lsrb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lsrb_div.sv @@
// ----------------------------------------------------------------------------
// lsrb_div
// serial softsign divider: round(m*4096/(4096+m)), one quotient bit a cycle
// ----------------------------------------------------------------------------
module lsrb_div import lsrb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  // numerator 2*m*4096 + den, divisor 2*den; quotient < 4096 so 13 bits
  logic [29:0] num_q, num_d;
  logic [17:0] dvs_q, dvs_d;
  logic [29:0] rem_q, rem_d;
  logic [12:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [30:0] trial;
  logic [16:0] den;

  assign den = 17'd4096 + {1'b0, req_i.mag};

  always_comb begin
    num_d = num_q; dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      num_d  = {1'b0, req_i.mag, 13'd0} + {13'd0, den};
      dvs_d  = {den, 1'b0};
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 5'd30;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[29]};
      num_d = {num_q[28:0], 1'b0};
      if (trial >= {13'd0, dvs_q}) begin
        rem_d = 30'(trial - {13'd0, dvs_q});
        quo_d = {quo_q[11:0], 1'b1};
      end else begin
        rem_d = trial[29:0];
        quo_d = {quo_q[11:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; dvs_q <= dvs_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = {3'd0, quo_q};
endmodule

@@ rtl/leaky_softsign_reservoir_bank_top.sv @@
// ----------------------------------------------------------------------------
// leaky_softsign_reservoir_bank_top
// per-channel rings of q3.12 reservoir cells with softsign drive and leak mix
// ----------------------------------------------------------------------------
// channel   dir  payload
// req       in   req_type, channel, sample, age_index
// rsp       out  cell_value, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// one item at a time; a process item runs memory reads, products and saturation,
// then the serial divider (quotient bits, then a done flag), then leak mix,
// write-back and output; a read item runs the memory reads and output, a
// rejected item the first read state and output; then idle before the next
// after reset and after a channel count or bank size write, a clearing pass
// sweeps all 512 memory cells; no item is taken during it
// a result waits in the output register while the output is stalled; the next
// item runs meanwhile and holds in its last state until the register drains
module leaky_softsign_reservoir_bank_top import lsrb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsrb_if.sink                req,
  lsrb_if.source              rsp,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [3:0]  chan_cnt_q;
  logic [6:0]  bank_q;
  logic [12:0] leak_q;
  logic signed [15:0] in_gain_q, fb_gain_q;
  logic        clr_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 4'd1;
      bank_q     <= 7'd64;
      leak_q     <= 13'd4096;
      in_gain_q  <= 16'sd4096;
      fb_gain_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegChannelCount: chan_cnt_q <= cfg_data_i[3:0];
        RegBankSize:     bank_q     <= cfg_data_i[6:0];
        RegLeak:         leak_q     <= cfg_data_i[12:0];
        RegInputGain:    in_gain_q  <= cfg_data_i;
        RegFeedbackGain: fb_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign clr_req = cfg_we_i &&
                   (cfg_idx_i == RegChannelCount || cfg_idx_i == RegBankSize);

  logic [6:0] bank_eff;
  assign bank_eff = (bank_q > 7'(MaxBank)) ? 7'(MaxBank) : bank_q;

  state_e state_q, state_d;
  req_t   item_q;
  logic [AddrW-1:0] clr_q;
  logic [PtrW-1:0] wptr_q [MaxChannels];
  logic [PtrW-1:0] wp, newest, phys;
  logic [6:0] wp_next;
  logic signed [15:0] mem [Depth];
  logic signed [15:0] rdata_q, fb_q, old_q;
  logic [AddrW-1:0] raddr;
  logic        mem_we;
  logic [AddrW-1:0] waddr;
  logic signed [15:0] wdata;
  logic signed [33:0] prod_a_q, prod_b_q;
  logic signed [15:0] drive_q, drive_d, target_q, result_q;
  logic signed [34:0] dsum;
  logic signed [22:0] dsh;
  logic signed [29:0] mix_q;
  logic signed [16:0] diff;
  logic [12:0] lk;
  logic signed [17:0] msum;
  logic signed [17:0] mfl;
  rsp_t out_q;
  rsp_t res_q;
  logic out_v_q;
  logic bad;
  div_req_t dreq;
  div_rsp_t drsp;

  assign wp     = wptr_q[item_q.channel];
  assign newest = (wp != '0) ? wp - 1'b1 : PtrW'(bank_eff - 7'd1);
  assign phys   = ({1'b0, newest} >= {1'b0, item_q.age_index}) ?
                  newest - item_q.age_index :
                  PtrW'({1'b0, newest} + bank_eff[PtrW:0] - {1'b0, item_q.age_index});
  assign wp_next = ({1'b0, wp} + 7'd1 >= bank_eff) ? 7'd0 : {1'b0, wp} + 7'd1;
  assign bad = ({1'b0, item_q.channel} >= chan_cnt_q) || (bank_eff == 7'd0) ||
               (item_q.req_type == ReqRead && {1'b0, item_q.age_index} >= bank_eff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == AddrW'(Depth - 1)) state_d = StIdle;
      StIdle:  if (req.valid && req.ready) state_d = StRead1;
      StRead1: state_d = bad ? StOut : StRead2;
      StRead2: state_d = (item_q.req_type == ReqRead) ? StOut : StDrive;
      StDrive: state_d = StSat;
      StSat:   state_d = StDiv;
      StDiv:   if (drsp.done) state_d = StMix;
      StMix:   state_d = StMix2;
      StMix2:  state_d = StWrite;
      StWrite: state_d = StOut;
      StOut:   if (!out_v_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (clr_req) state_d = StClear;
  end

  // read address: aged cell for a read, newest then oldest for a process
  always_comb begin
    raddr = {item_q.channel, (item_q.req_type == ReqRead) ? phys : newest};
    if (state_q == StRead2) raddr = {item_q.channel, wp};
  end

  assign dsum = 35'(prod_a_q) + 35'(prod_b_q) + 35'sd2048;
  assign dsh  = 23'(dsum >>> 12);
  assign drive_d = (dsh > 23'sd32767) ? 16'sh7fff :
                   (dsh < -23'sd32768) ? 16'sh8000 : dsh[15:0];
  assign lk   = (leak_q > 13'd4096) ? 13'd4096 : leak_q;
  assign diff = 17'(target_q) - 17'(old_q);
  assign mfl  = 18'((mix_q + 30'sd2048) >>> 12);
  assign msum = 18'(old_q) + mfl;

  assign dreq.start = (state_q == StSat);
  assign dreq.mag   = drive_d[15] ? 16'(-17'(drive_d)) : drive_d;

  assign mem_we = (state_q == StClear) || (state_q == StWrite);
  assign waddr  = (state_q == StClear) ? clr_q : {item_q.channel, wp};
  assign wdata  = (state_q == StClear) ? 16'sd0 : result_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < MaxChannels; i++) wptr_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (clr_req) begin
        clr_q <= '0;
        for (int i = 0; i < MaxChannels; i++) wptr_q[i] <= '0;
      end else if (state_q == StClear) begin
        clr_q <= clr_q + 1'b1;
      end else if (state_q == StWrite) begin
        wptr_q[item_q.channel] <= wp_next[PtrW-1:0];
      end
      if (state_q == StOut && !out_v_q) out_v_q <= 1'b1;
      else if (rsp.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid && req.ready) item_q <= req.data;
    if (state_q == StRead2) fb_q <= rdata_q;
    if (state_q == StDrive) begin
      old_q    <= rdata_q;
      prod_a_q <= 34'(in_gain_q * item_q.sample);
      prod_b_q <= 34'(fb_gain_q * fb_q);
    end
    if (state_q == StSat) drive_q <= drive_d;
    if (state_q == StDiv && drsp.done)
      target_q <= drive_q[15] ? 16'(-17'(drsp.quo)) : drsp.quo;
    if (state_q == StMix) mix_q <= 30'($signed({17'd0, lk}) * diff);
    if (state_q == StMix2)
      result_q <= (msum > 18'sd32767) ? 16'sh7fff :
                  (msum < -18'sd32768) ? 16'sh8000 : msum[15:0];
    if (state_q == StRead1 && bad) res_q <= '{cell_value: '0, status: 1'b1};
    if (state_q == StRead2 && item_q.req_type == ReqRead)
      res_q <= '{cell_value: rdata_q, status: 1'b0};
    if (state_q == StWrite) res_q <= '{cell_value: result_q, status: 1'b0};
    if (state_q == StOut && !out_v_q) out_q <= res_q;
  end

  lsrb_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign req.ready = (state_q == StIdle) && !clr_req;
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;
endmodule

@@ rtl/lsrb_checker.sv @@
// ----------------------------------------------------------------------------
// lsrb_checker
// port-level checks on the reservoir bank
// ----------------------------------------------------------------------------
`include "leaky_softsign_reservoir_bank_top_assert.svh"
module lsrb_checker import lsrb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);
  `LSRB_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i))
  `LSRB_ASSERT(a_reject_zero, rsp_valid_i && rsp_data_i.status == 1'b1, rsp_data_i.cell_value == '0)
  `LSRB_ASSERT_NEXT(a_one_at_a_time, req_valid_i && req_ready_i, !req_ready_i)
endmodule

bind leaky_softsign_reservoir_bank_top lsrb_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_data_i(rsp.data)
);
